/* rtl/gray_blur3x3_downsample2_assert.svh */
// ----------------------------------------------------------------------------
// gray_blur3x3_downsample2 assertion macros
// Shared concurrent assertion forms, clocked on rising edge, reset masked.
// ----------------------------------------------------------------------------
`ifndef GRAY_BLUR3X3_DOWNSAMPLE2_ASSERT_SVH
`define GRAY_BLUR3X3_DOWNSAMPLE2_ASSERT_SVH

// same-cycle implication
`define GBD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gbd_pkg.sv */
// ----------------------------------------------------------------------------
// gbd_pkg
// Sizes, register codes and shared types of the blur/decimate block.
// ----------------------------------------------------------------------------
package gbd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 13;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int MAXC_W    = (ADDR_W > ROW_W) ? ADDR_W : ROW_W;
    localparam int CMP_W     = (MAXC_W + 1 > CFG_W) ? MAXC_W + 1 : CFG_W;
    localparam int COL_SUM_W = PIX_W + 2;
    localparam int TOTAL_W   = COL_SUM_W + 2;
    localparam int WEIGHT_SHIFT = 4;
    localparam int ROUND_BIAS   = 8;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_ENABLE = 2'd2;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // one source column after the line stores, ready for horizontal filtering
    typedef struct packed {
        logic [COL_SUM_W-1:0] col_sum;
        logic                 emit;
        logic                 odd_col;
        logic                 left_rep;
        logic                 row_last;
        logic                 frame_last;
    } t_col_entry;

    typedef struct packed {
        logic s1_valid;
    } t_front_stat;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_queue_stat;

endpackage

/* rtl/gbd_front.sv */
// ----------------------------------------------------------------------------
// gbd_front
// Raster counters, two line stores and vertical [1 2 1] column sums.
// ----------------------------------------------------------------------------
module gbd_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [gbd_pkg::CFG_W-1:0]  i_width,
    input  logic [gbd_pkg::CFG_W-1:0]  i_height,
    input  logic                       i_in_valid,
    input  logic [gbd_pkg::PIX_W-1:0]  i_pixel_in,
    output logic                       o_in_stall,
    output logic                       o_push,
    output gbd_pkg::t_col_entry        o_entry,
    input  logic                       i_q_full,
    output gbd_pkg::t_front_stat       o_stat
);
    import gbd_pkg::*;

    logic [PIX_W-1:0] above_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] centre_mem [MAX_WIDTH];

    logic [ADDR_W-1:0] r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_s1_valid, n_s1_valid;

    logic [PIX_W-1:0] r_above_rd, r_centre_rd, r_pix;
    logic             r_odd_row, r_top_rep;
    logic             r_emit, r_odd_col, r_left_rep, r_row_last, r_frame_last;

    logic [CMP_W-1:0]  w_eff, h_eff, col_ext, row_ext, c_ext, row_adj, row_cur, c_nxt, row_inc;
    logic [ADDR_W-1:0] addr;
    logic              accept, odd_row, odd_col, last_row, last_col;
    logic [PIX_W-1:0]  top, mid, bot;

    // effective sizes, clamped to the supported range
    always_comb begin
        w_eff = CMP_W'(i_width);
        if (w_eff < CMP_W'(2)) w_eff = CMP_W'(2);
        if (w_eff > CMP_W'(MAX_WIDTH)) w_eff = CMP_W'(MAX_WIDTH);
        h_eff = CMP_W'(i_height);
        if (h_eff < CMP_W'(1)) h_eff = CMP_W'(1);
        if (h_eff > CMP_W'(MAX_HEIGHT)) h_eff = CMP_W'(MAX_HEIGHT);
    end

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_s1_valid && i_q_full;
    assign o_push     = r_s1_valid && !i_q_full;

    // position of this pixel; a size shrunk mid-frame restarts row or frame
    always_comb begin
        col_ext = CMP_W'(r_col);
        row_ext = CMP_W'(r_row);
        if (col_ext >= w_eff) begin
            c_ext   = '0;
            row_adj = row_ext + CMP_W'(1);
        end else begin
            c_ext   = col_ext;
            row_adj = row_ext;
        end
        row_cur = (row_adj >= h_eff) ? '0 : row_adj;
        c_nxt   = c_ext + CMP_W'(1);
        row_inc = row_cur + CMP_W'(1);
        if (c_nxt >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = c_nxt[ADDR_W-1:0];
            n_row = row_cur[ROW_W-1:0];
        end
        addr     = c_ext[ADDR_W-1:0];
        odd_row  = row_cur[0];
        odd_col  = c_ext[0];
        last_row = (row_cur == h_eff - CMP_W'(1));
        last_col = (c_ext == w_eff - CMP_W'(1));
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) n_s1_valid = 1'b1;
        else if (o_push) n_s1_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // line stores: read old contents, then write this pixel at the same column
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_above_rd  <= above_mem[addr];
            r_centre_rd <= centre_mem[addr];
            if (odd_row) above_mem[addr] <= i_pixel_in;
            else centre_mem[addr] <= i_pixel_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix        <= i_pixel_in;
            r_odd_row    <= odd_row;
            r_top_rep    <= odd_row ? (row_cur == CMP_W'(1)) : (row_cur == '0);
            r_emit       <= (odd_row || last_row) && (odd_col || last_col);
            r_odd_col    <= odd_col;
            r_left_rep   <= odd_col ? (c_ext < CMP_W'(3)) : (c_ext == '0);
            r_row_last   <= last_col;
            r_frame_last <= last_col && last_row;
        end
    end

    // vertical taps; top edge replicates the row below it
    always_comb begin
        if (r_odd_row) begin
            mid = r_centre_rd;
            bot = r_pix;
            top = r_top_rep ? r_centre_rd : r_above_rd;
        end else begin
            mid = r_pix;
            bot = r_pix;
            top = r_top_rep ? r_pix : r_above_rd;
        end
        o_entry.col_sum    = COL_SUM_W'(top) + {1'b0, mid, 1'b0} + COL_SUM_W'(bot);
        o_entry.emit       = r_emit;
        o_entry.odd_col    = r_odd_col;
        o_entry.left_rep   = r_left_rep;
        o_entry.row_last   = r_row_last;
        o_entry.frame_last = r_frame_last;
    end

    assign o_stat.s1_valid = r_s1_valid;

endmodule

/* rtl/gbd_queue.sv */
// ----------------------------------------------------------------------------
// gbd_queue
// Small first-in first-out buffer of column entries between front and back.
// ----------------------------------------------------------------------------
module gbd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  gbd_pkg::t_col_entry  i_entry,
    input  logic                 i_pop,
    output gbd_pkg::t_col_entry  o_entry,
    output gbd_pkg::t_queue_stat o_stat
);
    import gbd_pkg::*;

    t_col_entry         r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + Q_CNT_W'(1);
        else if (!i_push && i_pop) n_count = r_count - Q_CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) r_wr_ptr <= Q_PTR_W'((32'(r_wr_ptr) + 1) % Q_DEPTH);
            if (i_pop) r_rd_ptr <= Q_PTR_W'((32'(r_rd_ptr) + 1) % Q_DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_entry;
    end

    assign o_entry      = r_slot[r_rd_ptr];
    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

/* rtl/gbd_back.sv */
// ----------------------------------------------------------------------------
// gbd_back
// Column-sum window, horizontal [1 2 1] filter, rounding and output register.
// ----------------------------------------------------------------------------
module gbd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_round_enable,
    input  gbd_pkg::t_col_entry       i_entry,
    input  logic                      i_q_empty,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [gbd_pkg::PIX_W-1:0] o_pixel_out,
    output logic                      o_row_last,
    output logic                      o_frame_last
);
    import gbd_pkg::*;

    logic [COL_SUM_W-1:0] r_win1, r_win2;
    logic [COL_SUM_W-1:0] left, centre, right;
    logic [TOTAL_W-1:0]   total;
    logic                 out_free, r_out_valid, n_out_valid;
    logic [PIX_W-1:0]     r_pixel;
    logic                 r_row_last, r_frame_last;

    assign out_free = !r_out_valid || !i_out_stall;
    // columns that give no output never wait for the output register
    assign o_pop    = !i_q_empty && (!i_entry.emit || out_free);

    // window taps seen after this column shifts in
    always_comb begin
        if (i_entry.odd_col) begin
            centre = r_win2;
            right  = i_entry.col_sum;
            left   = i_entry.left_rep ? r_win2 : r_win1;
        end else begin
            centre = i_entry.col_sum;
            right  = i_entry.col_sum;
            left   = i_entry.left_rep ? i_entry.col_sum : r_win2;
        end
        total = TOTAL_W'(left) + {1'b0, centre, 1'b0} + TOTAL_W'(right);
        if (i_round_enable) total = total + TOTAL_W'(ROUND_BIAS);
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_pop && i_entry.emit) n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_win1      <= '0;
            r_win2      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_win1 <= r_win2;
                r_win2 <= i_entry.col_sum;
            end
        end
    end

    // weights total 16 and 16*255+8 still fits, so the top bits never overflow
    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.emit) begin
            r_pixel      <= total[WEIGHT_SHIFT +: PIX_W];
            r_row_last   <= i_entry.row_last;
            r_frame_last <= i_entry.frame_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_pixel;
    assign o_row_last   = r_row_last;
    assign o_frame_last = r_frame_last;

endmodule

/* rtl/gray_blur3x3_downsample2.sv */
// ----------------------------------------------------------------------------
// gray_blur3x3_downsample2
// 3x3 binomial blur with 2:1 decimation of an 8-bit gray raster stream.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                   | payload
//  --------+-----+-----------------------------+-------------------------------
//  in      | in  | i_in_valid / o_in_stall     | i_pixel_in
//  out     | out | o_out_valid / i_out_stall   | o_pixel_out, o_row_last,
//          |     |                             | o_frame_last
//  cfg     | in  | i_cfg_we (no handshake back)| i_cfg_index, i_cfg_data
//
//  One pixel accepted per clock while o_in_stall is low; a result passes the
//  line-store read, queue and output register. Throughput, one column a cycle
//  when unstalled, is set by the single-port line-store access.
//  Reset (synchronous, active low) clears counters, queue, window and config;
//  line stores keep garbage until written, which no legal stream reads.
//  An output stall backs up the four-entry queue before input stall rises.
// ----------------------------------------------------------------------------
module gray_blur3x3_downsample2 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [gbd_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gbd_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                          o_row_last,
    output logic                          o_frame_last,
    input  logic                          i_cfg_we,
    input  logic [gbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gbd_pkg::CFG_W-1:0]     i_cfg_data
);
    import gbd_pkg::*;

    `include "gray_blur3x3_downsample2_assert.svh"

    // config regs: user must write them only with the pipe empty; unenforced
    logic [CFG_W-1:0] r_width, r_height;
    logic             r_round;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_round  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                REG_ROUND_ENABLE: r_round  <= i_cfg_data[0];
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    t_col_entry  front_entry, queue_entry;
    t_front_stat front_stat;
    t_queue_stat queue_stat;
    logic        push, pop;

    // front: position tracking, line stores, vertical sums
    gbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_in_valid (i_in_valid),
        .i_pixel_in (i_pixel_in),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_entry    (front_entry),
        .i_q_full   (queue_stat.full),
        .o_stat     (front_stat)
    );

    // decoupling queue, lets each side stall on its own
    gbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_entry (queue_entry),
        .o_stat  (queue_stat)
    );

    // back: horizontal filter, decimation and output register
    gbd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_round_enable (r_round),
        .i_entry        (queue_entry),
        .i_q_empty      (queue_stat.empty),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_out    (o_pixel_out),
        .o_row_last     (o_row_last),
        .o_frame_last   (o_frame_last)
    );

    // frame end is always the end of a row
    `GBD_ASSERT_IMPL(a_frame_ends_row, i_clk, i_rst_n, o_out_valid && o_frame_last,
        o_row_last, "frame_last without row_last")
    // queue occupancy never exceeds its depth
    `GBD_ASSERT_IMPL(a_queue_bound, i_clk, i_rst_n, 1'b1,
        queue_stat.count <= Q_CNT_W'(Q_DEPTH), "queue overflow")
    // an accepted request always lands in the front stage register
    `GBD_ASSERT_NEXT(a_accept_held, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        front_stat.s1_valid, "accepted request lost")

endmodule

/* dv/gray_blur3x3_downsample2_tb.sv */
// ----------------------------------------------------------------------------
// gray_blur3x3_downsample2_tb
// Self-checking bench for the 3x3 binomial blur / 2:1 decimator. A queue of
// source pixels feeds a driver with random request gaps. A monitor with
// random output stalls checks every result against a cycle-free predictor
// of the filter: blurred value, row end and frame end.
// ----------------------------------------------------------------------------
module gray_blur3x3_downsample2_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbd_pkg::*;

    // ------------------------------------------------------------------------
    // bench constants
    // ------------------------------------------------------------------------
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;  // hang guard
    localparam int unsigned HOLD_OFF     = 10;         // outlasts the pipeline drain
    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned WIDE_ITEMS   = 40;
    // index past the last register; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum int unsigned {
        STYLE_UNIFORM,   // any gray level
        STYLE_EXTREME,   // only black and white
        STYLE_FLAT,      // near-constant level
        STYLE_RAMP       // incrementing level
    } t_pixel_style;

    // one expected output of the decimator
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_last;
        logic             frame_last;
    } t_reduced;

    // ------------------------------------------------------------------------
    // DUT connections, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [PIX_W-1:0]     in_pixel  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [PIX_W-1:0]     out_pixel;
    logic                 out_row_last;
    logic                 out_frame_last;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    gray_blur3x3_downsample2 u_top (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_pixel_in   (in_pixel),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_pixel_out  (out_pixel),
        .o_row_last   (out_row_last),
        .o_frame_last (out_frame_last),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor state: shadow registers, line stores, 3-column window and
    // raster position; reset values match the block's reset
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0] cfg_width  = WIDTH_RESET;
    logic [CFG_W-1:0] cfg_height = HEIGHT_RESET;
    logic             cfg_round  = 1'b1;

    logic [PIX_W-1:0] above_mem  [MAX_WIDTH];   // last odd source row
    logic [PIX_W-1:0] centre_mem [MAX_WIDTH];   // last even source row
    logic [23:0]      window [3] = '{default: '0};  // {bot, mid, top} per column
    int unsigned      col_pos = 0;
    int unsigned      row_pos = 0;

    // bench bookkeeping
    logic [PIX_W-1:0] source_q [$];    // pixels waiting for the driver
    t_reduced         reduced_q [$];   // outputs predicted, not yet seen
    t_reduced         predicted;
    t_reduced         want;
    int unsigned      px_queued   = 0;
    int unsigned      px_accepted = 0;
    int unsigned      checked     = 0;
    int unsigned      mismatches  = 0;
    int unsigned      cfg_writes  = 0;
    int unsigned      phases      = 0;
    int unsigned      cycle_count = 0;
    int unsigned      gap_left    = 0;
    int unsigned      stall_left  = 0;
    bit               drv_calm    = 1'b0;
    bit               mon_calm    = 1'b0;
    logic [PIX_W-1:0] flat_level  = '0;
    logic [PIX_W-1:0] ramp_level  = '0;

    // sizes after clamping to what the block supports
    function automatic int unsigned eff_width();
        if (cfg_width < 2) return 2;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height < 1) return 1;
        if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
        return cfg_height;
    endfunction

    // vertical [1 2 1] over one packed column
    function automatic int unsigned col_weight(input logic [23:0] v);
        return int'(v[7:0]) + 2 * int'(v[15:8]) + int'(v[23:16]);
    endfunction

    // Advance the filter by one source pixel. Returns 1 when this pixel
    // completes an output window, with the expected output in res.
    function automatic bit reduce_pixel(input logic [PIX_W-1:0] pix, output t_reduced res);
        int unsigned ew, eh, c, r, total;
        logic [PIX_W-1:0] top, mid, bot;
        logic [23:0] left_col, mid_col, right_col;
        bit row_ok, col_ok, last_col;
        ew  = eff_width();
        eh  = eff_height();
        res = '0;
        // a size shrunk mid-frame takes effect here
        if (col_pos >= ew) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= eh) row_pos = 0;
        c = col_pos;
        r = row_pos;

        if (r % 2 == 1) begin
            mid = centre_mem[c];
            bot = pix;
            top = (r == 1) ? mid : above_mem[c];
            above_mem[c] = pix;
        end else begin
            mid = pix;
            bot = pix;
            top = (r == 0) ? pix : above_mem[c];
            centre_mem[c] = pix;
        end
        window[0] = window[1];
        window[1] = window[2];
        window[2] = {bot, mid, top};

        row_ok   = (r % 2 == 1) || (r == eh - 1);
        col_ok   = (c % 2 == 1) || (c == ew - 1);
        last_col = (c == ew - 1);
        if (c % 2 == 1) begin
            mid_col   = window[1];
            right_col = window[2];
            left_col  = (c >= 3) ? window[0] : mid_col;
        end else begin
            mid_col   = window[2];
            right_col = mid_col;
            left_col  = (c > 0) ? window[1] : mid_col;
        end
        total = col_weight(left_col) + 2 * col_weight(mid_col) + col_weight(right_col);
        if (cfg_round) total += ROUND_BIAS;
        res.pixel      = PIX_W'(total >> WEIGHT_SHIFT);
        res.row_last   = last_col;
        res.frame_last = last_col && (r == eh - 1);

        col_pos = c + 1;
        if (col_pos >= ew) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= eh) row_pos = 0;
        end
        return row_ok && col_ok;
    endfunction

    // pixels needed to close the current frame, 0 when sitting at its start
    function automatic int unsigned pixels_to_frame_end();
        int unsigned ew, eh, c, r;
        ew = eff_width();
        eh = eff_height();
        c  = col_pos;
        r  = row_pos;
        if (c == 0 && r == 0) return 0;
        if (c >= ew) begin
            c = 0;
            r++;
        end
        if (r >= eh) r = 0;
        return ew * eh - (r * ew + c);
    endfunction

    // idle length: mostly short, now and then long
    function automatic int unsigned draw_gap();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return $urandom_range(1, 3);
        if (sel < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PIX_W-1:0] draw_pixel(input t_pixel_style style);
        case (style)
            STYLE_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            STYLE_FLAT:    return flat_level ^ PIX_W'($urandom_range(0, 3));
            STYLE_RAMP: begin
                ramp_level++;
                return ramp_level;
            end
            default:       return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_one(input logic [PIX_W-1:0] pix);
        source_q.push_back(pix);
        px_queued++;
    endtask

    task automatic queue_pixels(input int unsigned n, input t_pixel_style style);
        flat_level = PIX_W'($urandom_range(0, 255));
        for (int unsigned i = 0; i < n; i++) queue_one(draw_pixel(style));
        phases++;
    endtask

    // one register write per call; end_writes drops the enable afterwards
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width  = data;
            REG_IMAGE_HEIGHT: cfg_height = data;
            REG_ROUND_ENABLE: cfg_round  = data[0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Hold the sender until every queued pixel is taken and every output is
    // back, then let pixels that complete no window leave the pipeline too.
    task automatic settle();
        while (px_accepted != px_queued || reduced_q.size() != 0) @(posedge i_clk);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // driver: presents pixels from source_q; payload holds while stalled.
    // The prediction is made on the edge where the request is accepted.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                if (reduce_pixel(in_pixel, predicted)) reduced_q.push_back(predicted);
                px_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (source_q.size() != 0) begin
                    in_valid <= 1'b1;
                    in_pixel <= source_q.pop_front();
                    // back-to-back requests most of the time
                    gap_left = (drv_calm || $urandom_range(0, 2) != 0) ? 0 : draw_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
            // occasional stretches with no gaps at all
            if ($urandom_range(0, 63) == 0) drv_calm = !drv_calm;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random output stalls, field-by-field check of each result
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (reduced_q.size() == 0) begin
                    $error("output with nothing expected: pixel_out %0d", out_pixel);
                    mismatches++;
                end else begin
                    want = reduced_q.pop_front();
                    checked++;
                    if (out_pixel !== want.pixel) begin
                        $error("pixel_out mismatch: expected %0d, actual %0d",
                               want.pixel, out_pixel);
                        mismatches++;
                    end
                    if (out_row_last !== want.row_last) begin
                        $error("row_last mismatch: expected %0d, actual %0d",
                               want.row_last, out_row_last);
                        mismatches++;
                    end
                    if (out_frame_last !== want.frame_last) begin
                        $error("frame_last mismatch: expected %0d, actual %0d",
                               want.frame_last, out_frame_last);
                        mismatches++;
                    end
                end
            end
            // long stalls back the output queue up into the input stall
            if (stall_left == 0 && !mon_calm && $urandom_range(0, 3) == 0)
                stall_left = draw_gap();
            out_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
            if ($urandom_range(0, 63) == 0) mon_calm = !mon_calm;
        end
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned rand_items;
        int unsigned sel;
        int unsigned n;
        int unsigned fsize;
        logic [CFG_W-1:0] new_w;
        logic [CFG_W-1:0] new_h;
        t_pixel_style style;
        bit at_start;

        rand_items = 0;
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // sizes below range clamp to 2x1; a write past the last register
        // is dropped; saturated white must stay 255 with rounding on
        write_reg(REG_IMAGE_WIDTH, 13'd0);
        write_reg(REG_IMAGE_HEIGHT, 13'd0);
        write_reg(REG_ROUND_ENABLE, 13'd1);
        write_reg(REG_SPARE, 13'h1FFF);
        end_writes();
        queue_one(8'hFF);
        queue_one(8'hFF);
        queue_one(8'h00);
        queue_one(8'h00);
        phases++;
        settle();

        // odd width and height: right column and bottom row replicated,
        // truncation on a black/white checkerboard
        write_reg(REG_IMAGE_WIDTH, 13'd3);
        write_reg(REG_IMAGE_HEIGHT, 13'd3);
        write_reg(REG_ROUND_ENABLE, 13'd0);
        end_writes();
        for (int i = 0; i < 9; i++) queue_one((i % 2 == 1) ? 8'h00 : 8'hFF);
        phases++;
        settle();

        // width 1 clamps to 2; only bit 0 of the rounding register counts
        write_reg(REG_IMAGE_WIDTH, 13'd1);
        write_reg(REG_IMAGE_HEIGHT, 13'd2);
        write_reg(REG_ROUND_ENABLE, 13'h1FFE);
        end_writes();
        for (int i = 0; i < 4; i++) queue_one(PIX_W'(i + 1));
        phases++;
        settle();

        write_reg(REG_IMAGE_WIDTH, 13'd4);
        write_reg(REG_ROUND_ENABLE, 13'h1FFF);
        end_writes();
        for (int i = 0; i < 8; i++) queue_one(((i / 2) % 2 == 1) ? 8'h00 : 8'hFF);
        phases++;
        settle();

        // random phases: mostly whole frames, some cut short mid-frame.
        // The width may only grow at a frame start so that no line store
        // entry is read before it was written.
        while (rand_items < RANDOM_ITEMS) begin
            settle();
            at_start = (col_pos == 0 && row_pos == 0);
            if ($urandom_range(0, 9) < 7) begin
                sel = $urandom_range(0, 19);
                if (sel < 12)      new_w = CFG_W'($urandom_range(2, 8));
                else if (sel < 17) new_w = CFG_W'($urandom_range(9, 24));
                else               new_w = CFG_W'($urandom_range(0, 1));
                if (!at_start && new_w > eff_width())
                    new_w = CFG_W'($urandom_range(0, eff_width()));
                write_reg(REG_IMAGE_WIDTH, new_w);
                sel = $urandom_range(0, 19);
                if (sel < 14)      new_h = CFG_W'($urandom_range(1, 6));
                else if (sel < 18) new_h = CFG_W'($urandom_range(7, 16));
                else               new_h = '0;
                write_reg(REG_IMAGE_HEIGHT, new_h);
                if ($urandom_range(0, 1) == 1)
                    write_reg(REG_ROUND_ENABLE, CFG_W'($urandom()));
                else
                    write_reg(REG_ROUND_ENABLE, CFG_W'($urandom_range(0, 1)));
                if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, CFG_W'($urandom()));
                end_writes();
            end
            style = t_pixel_style'($urandom_range(0, 3));
            fsize = eff_width() * eff_height();
            n = pixels_to_frame_end();
            if (n == 0) n = fsize;
            if ($urandom_range(0, 6) == 0)
                n = $urandom_range(1, fsize + eff_width());
            else if (fsize <= 60)
                n += fsize * $urandom_range(0, 2);
            queue_pixels(n, style);
            rand_items += n;
        end

        // close whatever frame the random part left open
        settle();
        n = pixels_to_frame_end();
        if (n != 0) queue_pixels(n, STYLE_UNIFORM);
        settle();

        // wide row, cut short: width above range clamps to the full line
        // store, so no row end comes within these pixels
        write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        write_reg(REG_ROUND_ENABLE, 13'd1);
        end_writes();
        queue_pixels(WIDE_ITEMS, STYLE_UNIFORM);
        settle();

        // tallest frame, cut short: the width shrinks mid-row, which starts
        // the next row; the height changes mid-frame, first to a value still
        // past the current row, then below it, which starts a new frame with
        // the counters kept
        write_reg(REG_IMAGE_WIDTH, 13'd2);
        write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
        write_reg(REG_ROUND_ENABLE, 13'd0);
        end_writes();
        queue_pixels(20, STYLE_UNIFORM);
        settle();
        write_reg(REG_IMAGE_HEIGHT, 13'd4096);
        end_writes();
        queue_pixels(20, STYLE_EXTREME);
        settle();
        write_reg(REG_IMAGE_HEIGHT, 13'd3);
        end_writes();
        queue_pixels(12, STYLE_RAMP);
        settle();

        $display("Checked %0d output pixels from %0d source pixels in %0d phases, %0d reg writes.",
                 checked, px_accepted, phases, cfg_writes);
        $display("Sizes from clamped 2x1 up to 4096 wide and 4096 tall, rounding on and off, %s",
                 "random gaps and stalls on both sides.");
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
